// ----- rtl/isl_pkg.sv -----
// Shared opcodes, status codes and the cell control type for the indexed shift list.
package isl_pkg;

    localparam int OP_W     = 3;
    localparam int POS_W    = 7;
    localparam int IO_W     = 32;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_APPEND   = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT   = 3'd1;
    localparam logic [OP_W-1:0] OP_REM_LAST = 3'd2;
    localparam logic [OP_W-1:0] OP_REM_AT   = 3'd3;
    localparam logic [OP_W-1:0] OP_CONTAINS = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADIDX = 2'd3;

    typedef struct packed {
        logic ins;
        logic del;
        logic cmp;
    } t_cell_ctl;

endpackage

// ----- rtl/isl_cell.sv -----
// One list slot: holds an entry, shifts with its neighbors, compares and taps its value.
module isl_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int CNT_W      = 7,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  isl_pkg::t_cell_ctl    i_ctl,
    input  logic                  i_exec,
    input  logic [CNT_W-1:0]      i_sel,
    input  logic [CNT_W-1:0]      i_count,
    input  logic [DATA_WIDTH-1:0] i_val,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    output logic [DATA_WIDTH-1:0] o_entry,
    output logic [DATA_WIDTH-1:0] o_tap,
    output logic                  o_hit
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

    logic [DATA_WIDTH-1:0] r_entry;
    logic [DATA_WIDTH-1:0] n_entry;
    logic [DATA_WIDTH-1:0] r_tap;
    logic [DATA_WIDTH-1:0] n_tap;
    logic                  r_hit;
    logic                  n_hit;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (MY_IDX == i_sel) begin
                n_entry = i_val;
            end else if (MY_IDX > i_sel) begin
                n_entry = i_left;
            end
        end else if (i_ctl.del) begin
            // Slots at and above the removed one pull from the right neighbor.
            if (MY_IDX >= i_sel) begin
                n_entry = i_right;
            end
        end
        n_tap = (i_ctl.del && (MY_IDX == i_sel)) ? r_entry : '0;
        n_hit = i_ctl.cmp && (MY_IDX < i_count) && (r_entry == i_val);
    end

    // The tap and match flag load only in the execute cycle, so they hold while
    // the result beat waits for the output register.
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (i_exec) begin
            r_tap <= n_tap;
            r_hit <= n_hit;
        end
    end

    assign o_entry = r_entry;
    assign o_tap   = r_tap;
    assign o_hit   = r_hit;

endmodule

// ----- rtl/indexed_shift_list_core.sv -----
// Top level of the indexed shift list: request control, cell chain and result register.
//
//  Channel  | Direction | Handshake         | Beat contents
//  ---------+-----------+-------------------+---------------------------------------------
//  request  | in        | i_valid / o_ready | i_operation, i_position, i_item_value
//  result   | out       | o_valid / i_ready | o_removed_value, o_found, o_entry_count,
//           |           |                   | o_status
//
// A request passes through capture, an execute state in which every cell shifts or
// compares in parallel, and a reduce state that ORs the cell taps and match flags into
// the result. The result register is separate, so a new request is taken while a result
// beat still waits; a held result only delays the reduce step of the following request.
// Reset clears the count and control state; the entries need no clearing pass.
module indexed_shift_list_core #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [isl_pkg::OP_W-1:0]            i_operation,
    input  logic [isl_pkg::POS_W-1:0]           i_position,
    input  logic signed [isl_pkg::IO_W-1:0]     i_item_value,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [isl_pkg::IO_W-1:0]     o_removed_value,
    output logic                                o_found,
    output logic [isl_pkg::POS_W-1:0]           o_entry_count,
    output logic [isl_pkg::STATUS_W-1:0]        o_status
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > isl_pkg::POS_W) ? CNT_W : isl_pkg::POS_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RED  = 2'd2;

    logic [1:0]                     r_state;
    logic [1:0]                     n_state;
    logic [isl_pkg::OP_W-1:0]       r_op;
    logic [isl_pkg::POS_W-1:0]      r_pos;
    logic [DATA_WIDTH-1:0]          r_val;
    logic [CNT_W-1:0]               r_count;
    logic [CNT_W-1:0]               n_count;
    logic [isl_pkg::STATUS_W-1:0]   r_status;
    logic [isl_pkg::STATUS_W-1:0]   n_status;

    logic                           r_out_valid;
    logic signed [isl_pkg::IO_W-1:0] r_removed;
    logic                           r_found;
    logic [isl_pkg::POS_W-1:0]      r_entry_count;
    logic [isl_pkg::STATUS_W-1:0]   r_out_status;

    isl_pkg::t_cell_ctl             w_ctl;
    logic                           w_exec;
    logic [CNT_W-1:0]               w_sel;
    logic                           w_full;
    logic                           w_empty;
    logic [CMP_W-1:0]               w_pos_ext;
    logic [CMP_W-1:0]               w_cnt_ext;
    logic [63:0]                    w_in_ext;
    logic                           w_out_load;

    logic [DATA_WIDTH-1:0]          w_entry [DEPTH];
    logic [DATA_WIDTH-1:0]          w_tap   [DEPTH];
    logic [DEPTH-1:0]               w_hit;
    logic [DEPTH-1:0]               w_tap_col [DATA_WIDTH];
    logic signed [DATA_WIDTH-1:0]   w_removed_raw;
    logic [63:0]                    w_removed_ext;
    logic                           w_found;

    assign o_ready  = (r_state == S_IDLE);
    assign w_exec   = (r_state == S_EXEC);
    assign w_in_ext = 64'(i_item_value);

    // Decide the outcome of the held request and drive the cells.
    always_comb begin
        w_full    = (r_count == CNT_W'(DEPTH));
        w_empty   = (r_count == '0);
        w_pos_ext = CMP_W'(r_pos);
        w_cnt_ext = CMP_W'(r_count);
        w_ctl     = '0;
        w_sel     = '0;
        n_count   = r_count;
        n_status  = isl_pkg::ST_OK;
        case (r_op)
            isl_pkg::OP_APPEND: begin
                if (w_full) begin
                    n_status = isl_pkg::ST_FULL;
                end else begin
                    w_ctl.ins = 1'b1;
                    w_sel     = r_count;
                    n_count   = r_count + 1'b1;
                end
            end
            isl_pkg::OP_INSERT: begin
                if (w_full) begin
                    n_status = isl_pkg::ST_FULL;
                end else if (w_pos_ext > w_cnt_ext) begin
                    n_status = isl_pkg::ST_BADIDX;
                end else begin
                    w_ctl.ins = 1'b1;
                    w_sel     = CNT_W'(w_pos_ext);
                    n_count   = r_count + 1'b1;
                end
            end
            isl_pkg::OP_REM_LAST: begin
                if (w_empty) begin
                    n_status = isl_pkg::ST_EMPTY;
                end else begin
                    w_ctl.del = 1'b1;
                    w_sel     = r_count - 1'b1;
                    n_count   = r_count - 1'b1;
                end
            end
            isl_pkg::OP_REM_AT: begin
                if (w_empty) begin
                    n_status = isl_pkg::ST_EMPTY;
                end else if (w_pos_ext >= w_cnt_ext) begin
                    n_status = isl_pkg::ST_BADIDX;
                end else begin
                    w_ctl.del = 1'b1;
                    w_sel     = CNT_W'(w_pos_ext);
                    n_count   = r_count - 1'b1;
                end
            end
            isl_pkg::OP_CONTAINS: begin
                w_ctl.cmp = 1'b1;
            end
            default: begin
            end
        endcase
        if (r_state != S_EXEC) begin
            w_ctl = '0;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [DATA_WIDTH-1:0] w_left;
            logic [DATA_WIDTH-1:0] w_right;
            if (gi == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_entry[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_entry[gi+1];
            end
            isl_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .CNT_W      (CNT_W),
                .INDEX      (gi)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_exec  (w_exec),
                .i_sel   (w_sel),
                .i_count (r_count),
                .i_val   (r_val),
                .i_left  (w_left),
                .i_right (w_right),
                .o_entry (w_entry[gi]),
                .o_tap   (w_tap[gi]),
                .o_hit   (w_hit[gi])
            );
        end
    endgenerate

    // At most one cell taps its value, so a per-bit OR recovers the removed entry.
    always_comb begin
        for (int b = 0; b < DATA_WIDTH; b++) begin
            for (int c = 0; c < DEPTH; c++) begin
                w_tap_col[b][c] = w_tap[c][b];
            end
        end
        for (int b = 0; b < DATA_WIDTH; b++) begin
            w_removed_raw[b] = |w_tap_col[b];
        end
    end

    assign w_removed_ext = 64'(w_removed_raw);
    assign w_found       = |w_hit;
    assign w_out_load    = (r_state == S_RED) && (!r_out_valid || i_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_RED;
            end
            S_RED: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EXEC) begin
                r_count <= n_count;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_op  <= i_operation;
            r_pos <= i_position;
            r_val <= w_in_ext[DATA_WIDTH-1:0];
        end
        if (r_state == S_EXEC) begin
            r_status <= n_status;
        end
        if (w_out_load) begin
            r_removed     <= w_removed_ext[isl_pkg::IO_W-1:0];
            r_found       <= w_found;
            r_entry_count <= isl_pkg::POS_W'(r_count);
            r_out_status  <= r_status;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_removed_value = r_removed;
    assign o_found         = r_found;
    assign o_entry_count   = r_entry_count;
    assign o_status        = r_out_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> (r_count == $past(r_count))
            || (r_count == CNT_W'($past(r_count) + 1'b1))
            || (r_count == CNT_W'($past(r_count) - 1'b1)))
        else $error("count moved by more than one in a request");

    a_found_only_contains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RED) && (r_op != isl_pkg::OP_CONTAINS) |-> !w_found)
        else $error("match flagged for a request that is not a search");

endmodule

// ----- tb/sv/tb_indexed_shift_list_core.sv -----
// Self-checking testbench for indexed_shift_list_core with random request and result pacing.
module tb_indexed_shift_list_core;

    localparam int LIST_DEPTH   = 64;
    localparam int RANDOM_ITEMS = 1600;
    localparam int POS_MAX      = (1 << isl_pkg::POS_W) - 1;
    localparam logic [isl_pkg::OP_W-1:0] OP_FIRST_UNUSED = 3'd5;
    localparam logic [isl_pkg::OP_W-1:0] OP_LAST_UNUSED  = 3'd7;
    localparam logic signed [isl_pkg::IO_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [isl_pkg::IO_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        logic [isl_pkg::OP_W-1:0]        op;
        logic [isl_pkg::POS_W-1:0]       pos;
        logic signed [isl_pkg::IO_W-1:0] val;
    } t_list_req;

    typedef struct {
        logic signed [isl_pkg::IO_W-1:0] removed;
        logic                            found;
        logic [isl_pkg::POS_W-1:0]       count;
        logic [isl_pkg::STATUS_W-1:0]    status;
    } t_list_res;

    typedef enum {PH_FILL, PH_DRAIN, PH_MIX} t_phase;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_valid = 1'b0;
    logic                            o_ready;
    logic [isl_pkg::OP_W-1:0]        i_operation = '0;
    logic [isl_pkg::POS_W-1:0]       i_position = '0;
    logic signed [isl_pkg::IO_W-1:0] i_item_value = '0;
    logic                            o_valid;
    logic                            i_ready = 1'b0;
    logic signed [isl_pkg::IO_W-1:0] o_removed_value;
    logic                            o_found;
    logic [isl_pkg::POS_W-1:0]       o_entry_count;
    logic [isl_pkg::STATUS_W-1:0]    o_status;

    // Predicted list contents and length.
    logic signed [isl_pkg::IO_W-1:0] list_mem [0:LIST_DEPTH-1];
    int                              list_len = 0;

    t_list_req requests_todo[$];
    t_list_res results_due[$];

    // Length as the generator expects it, used to aim positions.
    int gen_len = 0;
    logic signed [isl_pkg::IO_W-1:0] value_pool [0:7];

    int fail_count = 0;
    int accepted = 0;
    int checked = 0;
    int n_full = 0;
    int n_empty = 0;
    int n_badidx = 0;
    int n_hits = 0;
    int peak_len = 0;

    int send_gap = 0;
    int hold_left = 0;
    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;
    t_list_req drv_cur;
    t_list_req drv_next;
    t_list_res drv_res;
    t_list_res mon_exp;

    indexed_shift_list_core #(
        .DEPTH      (LIST_DEPTH),
        .DATA_WIDTH (isl_pkg::IO_W)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_operation     (i_operation),
        .i_position      (i_position),
        .i_item_value    (i_item_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_removed_value (o_removed_value),
        .o_found         (o_found),
        .o_entry_count   (o_entry_count),
        .o_status        (o_status)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic list_apply(input t_list_req rq, output t_list_res rs);
        int i;
        rs.removed = '0;
        rs.found   = 1'b0;
        rs.status  = isl_pkg::ST_OK;
        case (rq.op)
            isl_pkg::OP_APPEND: begin
                if (list_len >= LIST_DEPTH) begin
                    rs.status = isl_pkg::ST_FULL;
                end else begin
                    list_mem[list_len] = rq.val;
                    list_len++;
                end
            end
            isl_pkg::OP_INSERT: begin
                // A full list is refused before the position is looked at.
                if (list_len >= LIST_DEPTH) begin
                    rs.status = isl_pkg::ST_FULL;
                end else if (int'(rq.pos) > list_len) begin
                    rs.status = isl_pkg::ST_BADIDX;
                end else begin
                    for (i = list_len; i > int'(rq.pos); i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[rq.pos] = rq.val;
                    list_len++;
                end
            end
            isl_pkg::OP_REM_LAST: begin
                if (list_len == 0) begin
                    rs.status = isl_pkg::ST_EMPTY;
                end else begin
                    list_len--;
                    rs.removed = list_mem[list_len];
                end
            end
            isl_pkg::OP_REM_AT: begin
                if (list_len == 0) begin
                    rs.status = isl_pkg::ST_EMPTY;
                end else if (int'(rq.pos) >= list_len) begin
                    rs.status = isl_pkg::ST_BADIDX;
                end else begin
                    rs.removed = list_mem[rq.pos];
                    for (i = int'(rq.pos); i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            isl_pkg::OP_CONTAINS: begin
                for (i = 0; i < list_len; i++)
                    if (list_mem[i] == rq.val)
                        rs.found = 1'b1;
            end
            default: ;
        endcase
        rs.count = isl_pkg::POS_W'(list_len);
        case (rs.status)
            isl_pkg::ST_FULL:   n_full++;
            isl_pkg::ST_EMPTY:  n_empty++;
            isl_pkg::ST_BADIDX: n_badidx++;
            default: ;
        endcase
        if (rs.found)
            n_hits++;
        if (list_len > peak_len)
            peak_len = list_len;
    endtask

    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [isl_pkg::OP_W-1:0] pick_op(input t_phase ph);
        int r;
        int w_app;
        int w_ins;
        int w_has;
        int w_last;
        int w_at;
        r = $urandom_range(0, 99);
        case (ph)
            PH_FILL:  begin w_app = 40; w_ins = 40; w_has = 10; w_last = 4;  w_at = 4;  end
            PH_DRAIN: begin w_app = 4;  w_ins = 4;  w_has = 10; w_last = 40; w_at = 40; end
            default:  begin w_app = 20; w_ins = 20; w_has = 20; w_last = 18; w_at = 18; end
        endcase
        if (r < w_app)
            return isl_pkg::OP_APPEND;
        r -= w_app;
        if (r < w_ins)
            return isl_pkg::OP_INSERT;
        r -= w_ins;
        if (r < w_has)
            return isl_pkg::OP_CONTAINS;
        r -= w_has;
        if (r < w_last)
            return isl_pkg::OP_REM_LAST;
        r -= w_last;
        if (r < w_at)
            return isl_pkg::OP_REM_AT;
        return OP_FIRST_UNUSED
            + isl_pkg::OP_W'($urandom_range(0, OP_LAST_UNUSED - OP_FIRST_UNUSED));
    endfunction

    // Half the values come from a small pool so that searches hit and duplicates occur.
    function automatic logic signed [isl_pkg::IO_W-1:0] pick_value();
        if ($urandom_range(0, 1) == 0)
            return value_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    task automatic queue_request(input logic [isl_pkg::OP_W-1:0] op, input int pos,
                                 input logic signed [isl_pkg::IO_W-1:0] val);
        t_list_req rq;
        rq.op  = op;
        rq.pos = isl_pkg::POS_W'(pos);
        rq.val = val;
        requests_todo.push_back(rq);
        case (op)
            isl_pkg::OP_APPEND: if (gen_len < LIST_DEPTH) gen_len++;
            isl_pkg::OP_INSERT: if (gen_len < LIST_DEPTH && pos <= gen_len) gen_len++;
            isl_pkg::OP_REM_LAST: if (gen_len > 0) gen_len--;
            isl_pkg::OP_REM_AT: if (gen_len > 0 && pos < gen_len) gen_len--;
            default: ;
        endcase
    endtask

    // Request driver: presents queued beats and predicts each one as it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                drv_cur.op  = i_operation;
                drv_cur.pos = i_position;
                drv_cur.val = i_item_value;
                list_apply(drv_cur, drv_res);
                results_due.push_back(drv_res);
                accepted++;
            end
            if ($urandom_range(0, 149) == 0)
                send_calm = !send_calm;
            if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (requests_todo.size() > 0) begin
                drv_next = requests_todo.pop_front();
                i_operation  <= drv_next.op;
                i_position   <= drv_next.pos;
                i_item_value <= drv_next.val;
                i_valid      <= 1'b1;
                send_gap = pick_gap(send_calm);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result monitor: checks each beat against the oldest prediction and paces i_ready.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: result beat with nothing due: removed %0d found %0b %s %0d %0d",
                             $time, o_removed_value, o_found, "count/status",
                             o_entry_count, o_status);
                    fail_count++;
                end else begin
                    mon_exp = results_due.pop_front();
                    checked++;
                    if (o_removed_value !== mon_exp.removed) begin
                        $display("%0t: removed_value expected %0d got %0d",
                                 $time, mon_exp.removed, o_removed_value);
                        fail_count++;
                    end
                    if (o_found !== mon_exp.found) begin
                        $display("%0t: found expected %0b got %0b", $time, mon_exp.found, o_found);
                        fail_count++;
                    end
                    if (o_entry_count !== mon_exp.count) begin
                        $display("%0t: entry_count expected %0d got %0d",
                                 $time, mon_exp.count, o_entry_count);
                        fail_count++;
                    end
                    if (o_status !== mon_exp.status) begin
                        $display("%0t: status expected %0d got %0d", $time, mon_exp.status, o_status);
                        fail_count++;
                    end
                end
            end
            if ($urandom_range(0, 149) == 0)
                recv_calm = !recv_calm;
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    hold_left = pick_gap(recv_calm);
            end
        end
    end

    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        t_phase ph;
        logic [isl_pkg::OP_W-1:0] op;
        int pos;
        int n_random;
        int n_queued;
        int tail;
        int steps;
        int k;

        value_pool[0] = '0;
        value_pool[1] = -1;
        value_pool[2] = WORD_MIN;
        value_pool[3] = WORD_MAX;
        value_pool[4] = 1;
        for (k = 5; k < 8; k++)
            value_pool[k] = $urandom;

        // Directed opening: refusals on an empty list, extremes, and each operation.
        queue_request(isl_pkg::OP_REM_LAST, 0, 0);
        queue_request(isl_pkg::OP_REM_AT, POS_MAX, 0);
        queue_request(isl_pkg::OP_CONTAINS, 0, 0);
        queue_request(isl_pkg::OP_INSERT, 1, 7);
        queue_request(isl_pkg::OP_INSERT, 0, WORD_MIN);
        queue_request(isl_pkg::OP_APPEND, POS_MAX, WORD_MAX);
        queue_request(isl_pkg::OP_APPEND, 0, -1);
        queue_request(isl_pkg::OP_APPEND, 0, 0);
        queue_request(isl_pkg::OP_INSERT, 2, 5);
        queue_request(isl_pkg::OP_INSERT, 5, 77);
        queue_request(isl_pkg::OP_INSERT, 7, 9);
        queue_request(isl_pkg::OP_CONTAINS, POS_MAX, WORD_MIN);
        queue_request(isl_pkg::OP_CONTAINS, 0, 12345);
        queue_request(isl_pkg::OP_REM_AT, 6, 0);
        queue_request(isl_pkg::OP_REM_AT, 0, 0);
        queue_request(isl_pkg::OP_REM_AT, 2, 0);
        queue_request(isl_pkg::OP_REM_LAST, 0, 0);
        queue_request(OP_FIRST_UNUSED, POS_MAX, WORD_MIN);
        queue_request(isl_pkg::OP_W'(OP_FIRST_UNUSED + 1), 0, -1);
        queue_request(OP_LAST_UNUSED, 3, 0);
        queue_request(isl_pkg::OP_CONTAINS, 0, WORD_MAX);
        queue_request(isl_pkg::OP_CONTAINS, 0, -1);

        // Random phases that fill the list to the top, drain it, or wander in between.
        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            ph = t_phase'($urandom_range(0, 2));
            tail = (ph == PH_MIX) ? $urandom_range(20, 80) : $urandom_range(2, 6);
            steps = 0;
            while (tail > 0 && steps < 400) begin
                op = pick_op(ph);
                if (op == isl_pkg::OP_INSERT && $urandom_range(0, 6) != 0)
                    pos = $urandom_range(0, gen_len);
                else if (op == isl_pkg::OP_REM_AT && gen_len > 0 && $urandom_range(0, 6) != 0)
                    pos = $urandom_range(0, gen_len - 1);
                else
                    pos = $urandom_range(0, POS_MAX);
                queue_request(op, pos, pick_value());
                if (op <= isl_pkg::OP_CONTAINS)
                    n_random++;
                steps++;
                if (ph == PH_MIX || (ph == PH_FILL && gen_len == LIST_DEPTH) ||
                    (ph == PH_DRAIN && gen_len == 0))
                    tail--;
            end
        end
        n_queued = requests_todo.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every queued beat yields exactly one result, so wait for all of them.
        while (checked < n_queued)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d requests and %0d checked results;", accepted, checked);
        $display("the list peaked at %0d entries, refused %0d full, %0d empty, %0d bad index, %0d hits.",
                 peak_len, n_full, n_empty, n_badidx, n_hits);
        if (fail_count == 0 && results_due.size() == 0 && checked == n_queued) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
